FILE: rtl/stng_pkg.sv
// ----------------------------------------------------------------------------
// stng_pkg
// Shared constants, controller command bundle and the quarter-wave sine
// function used to build the sine table at elaboration.
// ----------------------------------------------------------------------------
package stng_pkg;

  localparam int PHASE_BITS_DEF     = 32;
  localparam int SINE_ADDR_BITS_DEF = 10;
  localparam int LENGTH_BITS_DEF    = 20;
  localparam int RAMP_SAMPLES_DEF   = 100;

  // Sample rate in hundredths of a hertz, and its width.
  localparam logic [22:0] RATE_CENTIHZ = 23'd4410000;
  localparam int          RATE_BITS    = 23;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int          FULL_SCALE  = 32767;

  localparam int FREQ_BITS = 22;
  localparam int DUR_BITS  = 20;
  localparam int VOL_BITS  = 16;
  localparam int PCM_BITS  = 16;
  localparam int SINE_BITS = 15;

  // Commands from the controller to the datapath, one strobe per step.
  typedef struct packed {
    logic load_note;  // latch note fields, clear phase and index
    logic div_mul;    // frequency times reciprocal of the sample rate
    logic div_chk;    // phase-step estimate and estimate times sample rate
    logic div_fix;    // correct the estimate, load the phase step
    logic look;       // sine lookup, envelope, done flag, advance phase
    logic mul_vol;    // sine times volume
    logic mul_env;    // times envelope, drop 15 bits
    logic recip;      // times reciprocal of the ramp length
    logic fix;        // quotient estimate and remainder
    logic out_load;   // correct, saturate, sign, load output register
  } cmd_t;

  // Q15 quarter-wave entry k: Taylor series to x^11 in Q30, rounded.
  function automatic logic [SINE_BITS-1:0] quarter_sine(input int unsigned k,
                                                        input int qb);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] s;
    logic signed [63:0] q;
    x  = (64'(k) * HALF_PI_Q30) >> qb;
    x2 = (x * x) >> 30;
    t  = x;
    s  = $signed(x);
    t  = ((t * x2) >> 30) / 64'd6;
    s  = s - $signed(t);
    t  = ((t * x2) >> 30) / 64'd20;
    s  = s + $signed(t);
    t  = ((t * x2) >> 30) / 64'd42;
    s  = s - $signed(t);
    t  = ((t * x2) >> 30) / 64'd72;
    s  = s + $signed(t);
    t  = ((t * x2) >> 30) / 64'd110;
    s  = s - $signed(t);
    if (s < 0) begin
      s = 64'sd0;
    end
    q = (s * 64'sd32767 + 64'sd536870912) >>> 30;
    return SINE_BITS'(q);
  endfunction

endpackage

FILE: rtl/stng_ctrl.sv
// ----------------------------------------------------------------------------
// stng_ctrl
// Sequencer: accepts one tick at a time, runs the phase-step division on a
// note start, steps the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module stng_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          note_start_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output stng_pkg::cmd_t cmd_o
);
  import stng_pkg::*;

  localparam int CNT_BITS = 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_MULV  = 3'd3;
  localparam logic [2:0] S_MULE  = 3'd4;
  localparam logic [2:0] S_RECIP = 3'd5;
  localparam logic [2:0] S_FIX   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  // divider sub-steps
  localparam logic [CNT_BITS-1:0] D_MUL = 2'd0;
  localparam logic [CNT_BITS-1:0] D_CHK = 2'd1;
  localparam logic [CNT_BITS-1:0] D_FIX = 2'd2;

  logic [2:0]          state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                accept;
  logic                out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load_note = note_start_i;
          cnt_d           = '0;
          state_d         = note_start_i ? S_DIV : S_LOOK;
        end
      end
      S_DIV: begin
        cnt_d = cnt_q + 1'b1;
        unique case (cnt_q)
          D_MUL: cmd_o.div_mul = 1'b1;
          D_CHK: cmd_o.div_chk = 1'b1;
          D_FIX: begin
            cmd_o.div_fix = 1'b1;
            state_d       = S_LOOK;
          end
          default: state_d = S_LOOK;
        endcase
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = S_MULV;
      end
      S_MULV: begin
        cmd_o.mul_vol = 1'b1;
        state_d       = S_MULE;
      end
      S_MULE: begin
        cmd_o.mul_env = 1'b1;
        state_d       = S_RECIP;
      end
      S_RECIP: begin
        cmd_o.recip = 1'b1;
        state_d     = S_FIX;
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/stng_datapath.sv
// ----------------------------------------------------------------------------
// stng_datapath
// Note state, reciprocal phase-step divider, sine table, envelope and the
// multiply / constant-divide chain that forms one PCM sample.
// ----------------------------------------------------------------------------
module stng_datapath #(
  parameter int PHASE_BITS     = stng_pkg::PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = stng_pkg::SINE_ADDR_BITS_DEF,
  parameter int LENGTH_BITS    = stng_pkg::LENGTH_BITS_DEF,
  parameter int RAMP_SAMPLES   = stng_pkg::RAMP_SAMPLES_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  stng_pkg::cmd_t                         cmd_i,
  input  logic [stng_pkg::FREQ_BITS-1:0]         freq_centihz_i,
  input  logic [stng_pkg::DUR_BITS-1:0]          duration_samples_i,
  input  logic [stng_pkg::VOL_BITS-1:0]          volume_q15_i,
  output logic signed [stng_pkg::PCM_BITS-1:0]   pcm_sample_o,
  output logic                                   note_done_o
);
  import stng_pkg::*;

  localparam int QB      = SINE_ADDR_BITS - 2;
  localparam int QSIZE   = 1 << QB;
  localparam int RB      = $clog2(RAMP_SAMPLES + 1);
  localparam int CW      = ((LENGTH_BITS > RB) ? LENGTH_BITS : RB) + 1;
  localparam int PW      = 16 + RB;           // scaled product before / RAMP
  localparam int QW      = 17;                // quotient, below 2^16
  localparam int P1W     = SINE_BITS + VOL_BITS;
  localparam int P2W     = P1W + RB;
  localparam logic [PW:0]   RECIP  = (PW + 1)'((64'd1 << PW) / RAMP_SAMPLES);
  localparam logic [RB-1:0] RAMP_R = RB'(RAMP_SAMPLES);

  // Phase step = floor(freq * 2^PHASE_BITS / rate). The reciprocal carries
  // FREQ_BITS extra bits, so the estimate is short by at most one.
  localparam int NW = PHASE_BITS + FREQ_BITS + 1;
  localparam int MW = FREQ_BITS + PHASE_BITS;   // frequency times reciprocal
  localparam int DW = PHASE_BITS + RATE_BITS;   // numerator, estimate times rate
  localparam logic [NW-1:0] STEP_ONE = {1'b1, {(PHASE_BITS + FREQ_BITS){1'b0}}};
  localparam logic [PHASE_BITS-1:0] STEP_RECIP =
    PHASE_BITS'(STEP_ONE / NW'(RATE_CENTIHZ));

  // Quarter-wave sine table, folded to constants at elaboration.
  logic [SINE_BITS-1:0] qwave [QSIZE+1];
  for (genvar g = 0; g <= QSIZE; g++) begin : g_qwave
    assign qwave[g] = quarter_sine(g, QB);
  end

  logic [PHASE_BITS-1:0]  phase_acc_q;
  logic [PHASE_BITS-1:0]  phase_step_q;
  logic [LENGTH_BITS-1:0] index_q;
  logic [LENGTH_BITS-1:0] length_q;
  logic [VOL_BITS-1:0]    volume_q;
  logic [FREQ_BITS-1:0]   freq_q;
  logic [MW-1:0]          step_pm_q;
  logic [PHASE_BITS-1:0]  step_q0_q;
  logic [DW-1:0]          step_qd_q;

  logic [SINE_BITS-1:0]   sabs_q;
  logic                   sneg_q;
  logic [RB-1:0]          env_q;
  logic                   done_q;
  logic [P1W-1:0]         prod1_q;
  logic [PW-1:0]          p_q;
  logic [2*PW:0]          pm_q;
  logic [QW-1:0]          q0_q;
  logic [PW-1:0]          rem_q;
  logic signed [PCM_BITS-1:0] pcm_q;
  logic                   note_done_q;

  // phase-step correction: bump the estimate when the remainder reaches rate
  logic [DW-1:0]         step_num;
  logic [DW-1:0]         step_rem;
  logic [PHASE_BITS-1:0] step_fix;
  assign step_num = DW'({freq_q, {PHASE_BITS{1'b0}}});
  assign step_rem = step_num - step_qd_q;
  assign step_fix = (step_rem >= DW'(RATE_CENTIHZ)) ? step_q0_q + 1'b1 : step_q0_q;

  // lookup and envelope
  logic [SINE_ADDR_BITS-1:0] addr;
  logic [1:0]                quad;
  logic [QB:0]               kidx;
  logic [CW-1:0]             ie, le, re;
  logic                      done_d;
  logic [RB-1:0]             env_d;
  assign addr = phase_acc_q[PHASE_BITS-1 -: SINE_ADDR_BITS];
  assign quad = addr[SINE_ADDR_BITS-1 -: 2];
  assign kidx = quad[0] ? ((QB + 1)'(QSIZE) - {1'b0, addr[QB-1:0]})
                        : {1'b0, addr[QB-1:0]};
  assign ie     = CW'(index_q);
  assign le     = CW'(length_q);
  assign re     = CW'(RAMP_SAMPLES);
  assign done_d = (ie >= le);

  always_comb begin
    env_d = RAMP_R;
    if (ie < re) begin
      env_d = RB'(ie);
    end
    // release ramp only for notes at least one ramp long
    if ((le >= re) && ((ie + re) > le)) begin
      env_d = RB'(le - ie);
    end
  end

  // multiply chain
  logic [P2W-1:0]  prod2;
  logic [QW-1:0]   q0_d;
  logic [QW-1:0]   qfix;
  logic [PCM_BITS-1:0] mag;
  assign prod2 = P2W'(prod1_q) * P2W'(env_q);
  assign q0_d  = pm_q[PW +: QW];
  assign qfix  = (rem_q >= PW'(RAMP_SAMPLES)) ? q0_q + 1'b1 : q0_q;
  assign mag   = (qfix > QW'(FULL_SCALE)) ? PCM_BITS'(FULL_SCALE) : PCM_BITS'(qfix);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc_q  <= '0;
      phase_step_q <= '0;
      index_q      <= '0;
      length_q     <= '0;
      volume_q     <= '0;
    end else begin
      if (cmd_i.load_note) begin
        phase_acc_q  <= '0;
        phase_step_q <= '0;
        index_q      <= '0;
        length_q     <= LENGTH_BITS'(duration_samples_i);
        volume_q     <= volume_q15_i;
      end else if (cmd_i.div_fix) begin
        phase_step_q <= step_fix;
      end else if (cmd_i.look && !done_d) begin
        phase_acc_q <= phase_acc_q + phase_step_q;
        index_q     <= index_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_note) begin
      freq_q <= freq_centihz_i;
    end
    if (cmd_i.div_mul) begin
      step_pm_q <= MW'(freq_q) * MW'(STEP_RECIP);
    end
    if (cmd_i.div_chk) begin
      step_q0_q <= step_pm_q[MW-1 -: PHASE_BITS];
      step_qd_q <= DW'(step_pm_q[MW-1 -: PHASE_BITS]) * DW'(RATE_CENTIHZ);
    end
    if (cmd_i.look) begin
      sabs_q <= qwave[kidx];
      sneg_q <= quad[1];
      env_q  <= env_d;
      done_q <= done_d;
    end
    if (cmd_i.mul_vol) begin
      prod1_q <= P1W'(sabs_q) * P1W'(volume_q);
    end
    if (cmd_i.mul_env) begin
      p_q <= prod2[P2W-1:15];
    end
    if (cmd_i.recip) begin
      pm_q <= (2 * PW + 1)'(p_q) * (2 * PW + 1)'(RECIP);
    end
    if (cmd_i.fix) begin
      q0_q  <= q0_d;
      rem_q <= p_q - PW'(q0_d * (QW + RB)'(RAMP_R));
    end
    if (cmd_i.out_load) begin
      note_done_q <= done_q;
      if (done_q) begin
        pcm_q <= '0;
      end else begin
        pcm_q <= sneg_q ? -$signed(mag) : $signed(mag);
      end
    end
  end

  assign pcm_sample_o = pcm_q;
  assign note_done_o  = note_done_q;

endmodule

FILE: rtl/sine_tone_note_generator.sv
// ----------------------------------------------------------------------------
// sine_tone_note_generator
// DDS sine tone with a linear attack/release envelope, one sample per tick.
// ----------------------------------------------------------------------------
// Steps: a plain tick runs lookup, volume and envelope multiplies, the
//   reciprocal multiply, correction and output load; note_start first
//   adds the three-step reciprocal phase-step divider. The single-issue
//   sequencer takes a new tick only after loading the last output sample.
// Reset: rst_ni clears the note state (length zero, so output is silent with
//   done set) and both handshakes; the sine table is constant.
// ----------------------------------------------------------------------------
module sine_tone_note_generator #(
  parameter int PHASE_BITS     = stng_pkg::PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = stng_pkg::SINE_ADDR_BITS_DEF,
  parameter int LENGTH_BITS    = stng_pkg::LENGTH_BITS_DEF,
  parameter int RAMP_SAMPLES   = stng_pkg::RAMP_SAMPLES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 note_start_i,
  input  logic [stng_pkg::FREQ_BITS-1:0]       freq_centihz_i,
  input  logic [stng_pkg::DUR_BITS-1:0]        duration_samples_i,
  input  logic [stng_pkg::VOL_BITS-1:0]        volume_q15_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [stng_pkg::PCM_BITS-1:0] pcm_sample_o,
  output logic                                 note_done_o
);
  import stng_pkg::*;

  cmd_t cmd;

  // Controller: takes a tick only when idle, so the input fields are used in
  // the accept cycle only (note fields latch there) and need no copy. The
  // output register lets the next tick enter while a sample beat waits.
  stng_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .note_start_i (note_start_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_o        (cmd)
  );

  // Datapath: phase-step divider by reciprocal multiply with one correction,
  // phase accumulator, sine table, envelope, then sine * volume * envelope /
  // (32768 * RAMP_SAMPLES) via a reciprocal multiply with one correction
  // step, saturated to full scale and signed.
  stng_datapath #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .LENGTH_BITS    (LENGTH_BITS),
    .RAMP_SAMPLES   (RAMP_SAMPLES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .freq_centihz_i     (freq_centihz_i),
    .duration_samples_i (duration_samples_i),
    .volume_q15_i       (volume_q15_i),
    .pcm_sample_o       (pcm_sample_o),
    .note_done_o        (note_done_o)
  );

endmodule

FILE: rtl/stng_checker.sv
// ----------------------------------------------------------------------------
// stng_checker
// Port-level checks for the tone generator, bound to the top level.
// ----------------------------------------------------------------------------
module stng_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic signed [15:0] pcm_sample_o,
  input logic              note_done_o
);

  // a finished note emits silence
  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && note_done_o) |-> (pcm_sample_o == 16'sd0))
    else $error("done beat carries a nonzero sample");

  // magnitude saturates at full scale, never the most negative code
  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pcm_sample_o != -16'sd32768))
    else $error("sample beat below negative full scale");

  // one tick at a time: no accept right after an accept
  a_single_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("tick accepted while previous tick in flight");

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(pcm_sample_o) && $stable(note_done_o)))
    else $error("stalled sample beat changed");

endmodule

bind sine_tone_note_generator stng_checker u_stng_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .pcm_sample_o (pcm_sample_o),
  .note_done_o  (note_done_o)
);

FILE: dv/tb_sine_tone_note_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sine_tone_note_generator
// Self-checking bench for the DDS sine tone note generator. It drives sample
// ticks over a valid/ready channel and keeps a bit-exact software copy of the
// phase accumulator, sine table and envelope. It compares every PCM beat
// in order.
// ----------------------------------------------------------------------------
module tb_sine_tone_note_generator;

  localparam int PHASE_W   = stng_pkg::PHASE_BITS_DEF;
  localparam int ADDR_W    = stng_pkg::SINE_ADDR_BITS_DEF;
  localparam int LEN_W     = stng_pkg::LENGTH_BITS_DEF;
  localparam int RAMP      = stng_pkg::RAMP_SAMPLES_DEF;
  localparam int QBITS     = ADDR_W - 2;
  localparam int QSIZE     = 1 << QBITS;
  localparam int FREQ_W    = stng_pkg::FREQ_BITS;
  localparam int DUR_W     = stng_pkg::DUR_BITS;
  localparam int VOL_W     = stng_pkg::VOL_BITS;
  localparam int PCM_W     = stng_pkg::PCM_BITS;
  localparam longint unsigned SAMPLE_RATE_CHZ = 64'd4410000;
  localparam longint unsigned NYQUIST_CHZ     = 64'd2205000;
  localparam int unsigned     PCM_MAX         = 32767;
  localparam int unsigned     TICK_GOAL       = 550;
  localparam int unsigned     CYCLE_LIMIT     = 400000;
  localparam int unsigned     DRAIN_CYCLES    = 60;

  typedef struct {
    logic signed [PCM_W-1:0] pcm;
    logic                    done;
  } pcm_beat_t;

  // Tone model plus the queue of PCM beats it still owes the output port.
  class tone_scoreboard;
    int unsigned         sine_quarter[0:QSIZE];
    bit [PHASE_W-1:0]    phase_acc;
    bit [PHASE_W-1:0]    phase_step;
    bit [LEN_W-1:0]      sample_index;
    bit [LEN_W-1:0]      note_length;
    bit [VOL_W-1:0]      note_volume;
    pcm_beat_t           pending_beats[$];
    int unsigned         errors;

    function new();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      for (int k = 0; k <= QSIZE; k++) begin
        x    = (longint'(k) * stng_pkg::HALF_PI_Q30) >> QBITS;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 5; n++) begin
          term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) begin
            acc = acc - longint'(term);
          end else begin
            acc = acc + longint'(term);
          end
        end
        if (acc < 0) begin
          acc = 0;
        end
        sine_quarter[k] = int'((acc * 32767 + (longint'(1) << 29)) >>> 30);
      end
      phase_acc    = '0;
      phase_step   = '0;
      sample_index = '0;
      note_length  = '0;
      note_volume  = '0;
      errors       = 0;
    endfunction

    task report(string what, int got, int want);
      $display("MISMATCH at %0t: %s got %0d, expected %0d", $time, what, got, want);
      errors++;
    endtask

    // Advance the tone state by one accepted tick and queue its beat.
    function void note_tick(bit start, bit [FREQ_W-1:0] freq, bit [DUR_W-1:0] dur,
                            bit [VOL_W-1:0] vol);
      pcm_beat_t        want;
      int unsigned      env;
      longint unsigned  mag;
      bit [ADDR_W-1:0]  addr;
      bit [1:0]         quad;
      bit [QBITS-1:0]   k;
      int unsigned      v;
      if (start) begin
        phase_step   = PHASE_W'((64'(freq) << PHASE_W) / SAMPLE_RATE_CHZ);
        note_length  = LEN_W'(dur);
        note_volume  = vol;
        phase_acc    = '0;
        sample_index = '0;
      end
      if (sample_index >= note_length) begin
        want.pcm  = '0;
        want.done = 1'b1;
        pending_beats.push_back(want);
        return;
      end
      env = RAMP;
      if (sample_index < RAMP) begin
        env = sample_index;
      end
      if (note_length >= RAMP && sample_index > note_length - RAMP) begin
        env = note_length - sample_index;
      end
      addr = phase_acc[PHASE_W-1 -: ADDR_W];
      quad = addr[ADDR_W-1 -: 2];
      k    = addr[QBITS-1:0];
      v    = quad[0] ? sine_quarter[QSIZE - k] : sine_quarter[k];
      mag  = v;
      mag  = mag * note_volume;
      mag  = mag * env;
      mag  = mag / (64'd32768 * RAMP);
      if (mag > PCM_MAX) begin
        mag = PCM_MAX;
      end
      want.pcm = PCM_W'(mag);
      if (quad[1]) begin
        want.pcm = -want.pcm;
      end
      want.done = 1'b0;
      pending_beats.push_back(want);
      phase_acc    = phase_acc + phase_step;
      sample_index = sample_index + 1'b1;
    endfunction

    task check_sample(logic signed [PCM_W-1:0] pcm, logic done);
      pcm_beat_t want;
      if (pending_beats.size() == 0) begin
        report("unexpected beat, pcm", int'(pcm), 0);
        return;
      end
      want = pending_beats.pop_front();
      if (pcm !== want.pcm) begin
        report("pcm_sample", int'(pcm), int'(want.pcm));
      end
      if (done !== want.done) begin
        report("note_done", int'(done), int'(want.done));
      end
    endtask
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    note_start_i;
  logic [FREQ_W-1:0]       freq_centihz_i;
  logic [DUR_W-1:0]        duration_samples_i;
  logic [VOL_W-1:0]        volume_q15_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [PCM_W-1:0] pcm_sample_o;
  logic                    note_done_o;

  tone_scoreboard tone_sb;
  int unsigned    ticks_sent;
  int unsigned    send_idle_pct;
  int unsigned    recv_stall_pct;
  int unsigned    cycle_count;

  sine_tone_note_generator u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .note_start_i       (note_start_i),
    .freq_centihz_i     (freq_centihz_i),
    .duration_samples_i (duration_samples_i),
    .volume_q15_i       (volume_q15_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .pcm_sample_o       (pcm_sample_o),
    .note_done_o        (note_done_o)
  );

  // 2 ns clock.
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Stall the output side at random; one assignment per falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Sample output beats at the rising edge and check them in order.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tone_sb.check_sample(pcm_sample_o, note_done_o);
    end
  end

  // Watchdog: bail out if the run hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic bit chance(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Drive one tick beat. Pick the idle profile from the tick count so the run
  // passes through slow receiver, slow sender, then full rate. Hold valid and
  // the payload until the beat is taken.
  task automatic send_tick(bit start, bit [FREQ_W-1:0] freq, bit [DUR_W-1:0] dur,
                           bit [VOL_W-1:0] vol);
    if (ticks_sent < TICK_GOAL / 3) begin
      send_idle_pct  = 26;
      recv_stall_pct = 78;
    end else if (ticks_sent < 2 * TICK_GOAL / 3) begin
      send_idle_pct  = 78;
      recv_stall_pct = 26;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
    @(negedge clk_i);
    while (chance(send_idle_pct)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    note_start_i       <= start;
    freq_centihz_i     <= freq;
    duration_samples_i <= dur;
    volume_q15_i       <= vol;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    tone_sb.note_tick(start, freq, dur, vol);
    ticks_sent++;
  endtask

  // Plain tick: note fields are ignored, so fill them with full-width noise.
  task automatic send_plain_ticks(int unsigned count);
    repeat (count) begin
      send_tick(1'b0, FREQ_W'($urandom), DUR_W'($urandom), VOL_W'($urandom));
    end
  endtask

  // One note: a start beat followed by plain ticks. Most notes play through
  // their end; some are cut short by the next start, and a few beats are
  // plain noise with random start bits.
  task automatic play_note();
    int unsigned      kind;
    bit [FREQ_W-1:0]  freq;
    bit [DUR_W-1:0]   dur;
    bit [VOL_W-1:0]   vol;
    int unsigned      follow;
    kind = $urandom_range(0, 99);
    freq = chance(80) ? FREQ_W'($urandom_range(0, NYQUIST_CHZ)) : FREQ_W'($urandom);
    vol  = chance(70) ? VOL_W'($urandom_range(0, 32768)) : VOL_W'($urandom);
    if (kind < 10) begin
      repeat ($urandom_range(1, 8)) begin
        send_tick(chance(30), FREQ_W'($urandom), DUR_W'($urandom), VOL_W'($urandom));
      end
      return;
    end else if (kind < 20) begin
      dur    = DUR_W'($urandom_range(0, 3));
      follow = dur + $urandom_range(0, 3);
    end else if (kind < 55) begin
      dur    = DUR_W'($urandom_range(4, RAMP - 1));
      follow = dur + $urandom_range(0, 2);
    end else if (kind < 85) begin
      dur    = DUR_W'($urandom_range(RAMP, RAMP + 30));
      follow = chance(80) ? dur + $urandom_range(0, 2) : $urandom_range(0, dur);
    end else begin
      // Long note: reach the flat part of the envelope at high volume.
      dur    = DUR_W'($urandom_range(2 * RAMP, (1 << DUR_W) - 1));
      vol    = VOL_W'($urandom_range(32768, (1 << VOL_W) - 1));
      follow = $urandom_range(RAMP, RAMP + 50);
    end
    send_tick(1'b1, freq, dur, vol);
    send_plain_ticks(follow);
  endtask

  initial begin
    tone_sb            = new();
    ticks_sent         = 0;
    cycle_count        = 0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    note_start_i       = 1'b0;
    freq_centihz_i     = '0;
    duration_samples_i = '0;
    volume_q15_i       = '0;
    out_ready_i        = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: silent after reset, zero-length note, Nyquist tone at max length
    // and saturating volume, aliasing tone on a short note, one-sample note.
    send_tick(1'b0, '1, '1, '1);
    send_tick(1'b1, '0, '0, '0);
    send_plain_ticks(1);
    send_tick(1'b1, FREQ_W'(NYQUIST_CHZ), '1, '1);
    send_plain_ticks(3);
    send_tick(1'b1, '1, DUR_W'(5), VOL_W'(32768));
    send_plain_ticks(6);
    send_tick(1'b1, FREQ_W'(1000000), DUR_W'(1), VOL_W'(32768));
    send_plain_ticks(2);

    while (ticks_sent < TICK_GOAL) begin
      play_note();
    end

    // Drop valid, drain the expected beats, then watch for strays.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tone_sb.pending_beats.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (tone_sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
